### hdl/pfa_pkg.sv
// Shared constants and controller/datapath interface types for the partition fit allocator.
package pfa_pkg;

   localparam int PARTITIONS_DEF = 8;

   localparam int KIND_W = 2;
   localparam int SLOT_W = 3;
   localparam int SIZE_W = 16;
   localparam int MODE_W = 2;

   localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

   localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

   typedef struct packed {
      logic accept;
      logic scan_en;
      logic commit;
   } pfa_cmd_type;

   typedef struct packed {
      logic scan_last;
   } pfa_status_type;

endpackage

### hdl/pfa_datapath.sv
// Datapath: partition size memory, allocated marks, scan pipeline and result register.
module pfa_datapath #(
   parameter int PARTITIONS = pfa_pkg::PARTITIONS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [pfa_pkg::MODE_W-1:0]  csr_wr_data,
   input  logic [pfa_pkg::KIND_W-1:0]  req_kind,
   input  logic [pfa_pkg::SLOT_W-1:0]  req_slot,
   input  logic [pfa_pkg::SIZE_W-1:0]  req_size,
   input  pfa_pkg::pfa_cmd_type        cmd,
   output pfa_pkg::pfa_status_type     status,
   output logic                        rsp_granted,
   output logic [pfa_pkg::SLOT_W-1:0]  rsp_chosen_slot
);

   localparam int IDX_W = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PARTITIONS - 1);

   logic [pfa_pkg::MODE_W-1:0] fit_mode_ff;
   logic [pfa_pkg::SIZE_W-1:0] size_mem [PARTITIONS];
   logic [PARTITIONS-1:0]      size_ok_ff;
   logic [PARTITIONS-1:0]      in_use_ff;

   logic [pfa_pkg::SIZE_W-1:0] want_ff;
   logic [pfa_pkg::SIZE_W-1:0] rd_data_ff;
   logic [pfa_pkg::SIZE_W-1:0] sel_size_ff;
   logic [pfa_pkg::SIZE_W-1:0] cur_size;
   logic [IDX_W-1:0]           addr_ff;
   logic [IDX_W-1:0]           rd_idx_ff;
   logic [IDX_W-1:0]           sel_ff;
   logic                       rd_ok_ff;
   logic                       issue_done_ff;
   logic                       stage_vld_ff;
   logic                       found_ff;
   logic                       granted_ff;
   logic [pfa_pkg::SLOT_W-1:0] chosen_ff;

   logic load_hit;
   logic qualify;
   logic better;
   logic take;

   // Loads to a slot outside the table are dropped.
   assign load_hit = cmd.accept && (req_kind == pfa_pkg::KIND_LOAD) &&
                     (32'(req_slot) < 32'(PARTITIONS));

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff <= pfa_pkg::MODE_FIRST;
      end else if (csr_wr_en) begin
         fit_mode_ff <= csr_wr_data;
      end
   end

   // Size memory: one write port for loads, one registered read port for the scan.
   always_ff @(posedge clock) begin
      if (load_hit) begin
         size_mem[IDX_W'(req_slot)] <= req_size;
      end
      rd_data_ff <= size_mem[addr_ff];
      rd_ok_ff   <= size_ok_ff[addr_ff];
   end

   // An entry never loaded since reset reads as size zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ok_ff <= '0;
      end else if (load_hit) begin
         size_ok_ff[IDX_W'(req_slot)] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff       <= '0;
         rd_idx_ff     <= '0;
         issue_done_ff <= 1'b0;
         stage_vld_ff  <= 1'b0;
      end else if (cmd.accept) begin
         addr_ff       <= '0;
         issue_done_ff <= 1'b0;
         stage_vld_ff  <= 1'b0;
      end else if (cmd.scan_en) begin
         stage_vld_ff <= !issue_done_ff;
         rd_idx_ff    <= addr_ff;
         if (!issue_done_ff) begin
            if (addr_ff == LAST_IDX) begin
               issue_done_ff <= 1'b1;
            end else begin
               addr_ff <= addr_ff + IDX_W'(1);
            end
         end
      end else begin
         stage_vld_ff <= 1'b0;
      end
   end

   assign cur_size = rd_ok_ff ? rd_data_ff : '0;
   assign qualify  = stage_vld_ff && !in_use_ff[rd_idx_ff] && (cur_size >= want_ff);

   always_comb begin
      case (fit_mode_ff)
         pfa_pkg::MODE_BEST:  better = cur_size < sel_size_ff;
         pfa_pkg::MODE_WORST: better = cur_size > sel_size_ff;
         default:             better = 1'b0;
      endcase
   end

   // Strict compares keep the lowest index on ties.
   assign take = qualify && (!found_ff || better);

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff    <= 1'b0;
         want_ff     <= '0;
         sel_ff      <= '0;
         sel_size_ff <= '0;
      end else if (cmd.accept) begin
         found_ff <= 1'b0;
         want_ff  <= req_size;
      end else if (cmd.scan_en && take) begin
         found_ff    <= 1'b1;
         sel_ff      <= rd_idx_ff;
         sel_size_ff <= cur_size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= '0;
      end else if (cmd.accept && (req_kind == pfa_pkg::KIND_RELEASE)) begin
         in_use_ff <= '0;
      end else if (cmd.commit && found_ff) begin
         in_use_ff[sel_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         granted_ff <= found_ff;
         chosen_ff  <= found_ff ? pfa_pkg::SLOT_W'(sel_ff) : '0;
      end
   end

   assign status.scan_last = cmd.scan_en && stage_vld_ff && (rd_idx_ff == LAST_IDX);
   assign rsp_granted      = granted_ff;
   assign rsp_chosen_slot  = chosen_ff;

endmodule

### hdl/pfa_ctrl.sv
// Controller: sequences each item through accept, scan (requests only) and result hand-off.
module pfa_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [pfa_pkg::KIND_W-1:0] req_kind,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  pfa_pkg::pfa_status_type    status,
   output pfa_pkg::pfa_cmd_type       cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   assign cmd.accept  = (state_ff == ST_IDLE) && req_valid;
   assign cmd.scan_en = (state_ff == ST_SCAN);
   // The result register is free when empty or when its transfer completes this cycle.
   assign cmd.commit  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= (req_kind == pfa_pkg::KIND_REQUEST) ? ST_SCAN : ST_DONE;
               end
            end
            ST_SCAN: begin
               if (status.scan_last) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (cmd.commit) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

### hdl/partition_fit_allocator.sv
// A load, release-all or undefined-kind item goes from transfer through the done state to the
// result register; a request first runs the scan that reads the size memory through its single
// read port, one partition per cycle; one item is in work at a time,
// and the next is taken while the previous result still waits in the output register.
module partition_fit_allocator #(
   parameter int PARTITIONS = pfa_pkg::PARTITIONS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [pfa_pkg::MODE_W-1:0] csr_wr_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [pfa_pkg::KIND_W-1:0] req_kind,
   input  logic [pfa_pkg::SLOT_W-1:0] req_slot,
   input  logic [pfa_pkg::SIZE_W-1:0] req_size,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_granted,
   output logic [pfa_pkg::SLOT_W-1:0] rsp_chosen_slot
);

   pfa_pkg::pfa_cmd_type    cmd;
   pfa_pkg::pfa_status_type status;

   pfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pfa_datapath #(
      .PARTITIONS (PARTITIONS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_kind        (req_kind),
      .req_slot        (req_slot),
      .req_size        (req_size),
      .cmd             (cmd),
      .status          (status),
      .rsp_granted     (rsp_granted),
      .rsp_chosen_slot (rsp_chosen_slot)
   );

`ifndef ASSERT_OFF
   // Only one item is in work: a transfer on the request side closes it for the next cycle.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request side open right after a transfer");

   // Finishing an item always presents its result.
   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("finished item did not present a result");

   // The end of a scan is only seen while scanning.
   a_scan_last: assert property (@(posedge clock) disable iff (reset)
      status.scan_last |-> (cmd.scan_en && req_stall))
      else $error("scan end outside a scan");

   // A granted partition lies inside the table.
   a_chosen_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_granted) |-> (32'(rsp_chosen_slot) < 32'(PARTITIONS)))
      else $error("granted partition outside the table");
`endif

endmodule

### verif/partition_fit_allocator_tb.sv
// Self-checking testbench for the partition fit allocator: random and directed transfers.
module partition_fit_allocator_tb;

   localparam logic [pfa_pkg::KIND_W-1:0] KIND_UNDEF = 2'd3;
   localparam logic [pfa_pkg::MODE_W-1:0] MODE_UNDEF = 2'd3;
   localparam int TABLE_DEPTH = pfa_pkg::PARTITIONS_DEF;
   localparam int QUIET_LIMIT = 4000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 30;

   typedef struct packed {
      logic [pfa_pkg::KIND_W-1:0] kind;
      logic [pfa_pkg::SLOT_W-1:0] slot;
      logic [pfa_pkg::SIZE_W-1:0] size;
   } alloc_item_type;

   typedef struct packed {
      logic                       granted;
      logic [pfa_pkg::SLOT_W-1:0] chosen;
   } alloc_grant_type;

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       csr_wr_en = 1'b0;
   logic [pfa_pkg::MODE_W-1:0] csr_wr_data = '0;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [pfa_pkg::KIND_W-1:0] req_kind = '0;
   logic [pfa_pkg::SLOT_W-1:0] req_slot = '0;
   logic [pfa_pkg::SIZE_W-1:0] req_size = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic                       rsp_granted;
   logic [pfa_pkg::SLOT_W-1:0] rsp_chosen_slot;

   alloc_item_type  item_q[$];
   alloc_grant_type grant_q[$];

   // Shadow copy of the partition table and the placement rule.
   logic [pfa_pkg::SIZE_W-1:0] part_size[TABLE_DEPTH];
   logic                       part_busy[TABLE_DEPTH];
   logic [pfa_pkg::MODE_W-1:0] fit_rule = pfa_pkg::MODE_FIRST;

   int  tx_idle_pct = 0;
   int  rx_stall_pct = 0;
   bit  hold_pending = 0;
   int  hold_left = 0;
   int  quiet_cycles = 0;
   int  mismatch_count = 0;
   int  items_taken = 0;
   int  results_seen = 0;
   int  grants_seen = 0;
   int  input_stall_cycles = 0;

   partition_fit_allocator uut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_slot        (req_slot),
      .req_size        (req_size),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_granted     (rsp_granted),
      .rsp_chosen_slot (rsp_chosen_slot)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      for (int j = 0; j < TABLE_DEPTH; j++) begin
         part_size[j] = '0;
         part_busy[j] = 1'b0;
      end
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   // Applies one item to the shadow table and returns the grant it should produce.
   function automatic alloc_grant_type alloc_predict(
      input logic [pfa_pkg::KIND_W-1:0] kind,
      input logic [pfa_pkg::SLOT_W-1:0] slot,
      input logic [pfa_pkg::SIZE_W-1:0] size);
      alloc_grant_type g;
      bit found;
      int sel;
      g = '0;
      found = 0;
      sel = 0;
      case (kind)
         pfa_pkg::KIND_LOAD: begin
            part_size[slot] = size;
         end
         pfa_pkg::KIND_REQUEST: begin
            for (int j = 0; j < TABLE_DEPTH; j++) begin
               if (!part_busy[j] && part_size[j] >= size) begin
                  if (!found) begin
                     found = 1;
                     sel = j;
                  end else if (fit_rule == pfa_pkg::MODE_BEST &&
                               part_size[j] < part_size[sel]) begin
                     sel = j;
                  end else if (fit_rule == pfa_pkg::MODE_WORST &&
                               part_size[j] > part_size[sel]) begin
                     sel = j;
                  end
               end
            end
            if (found) begin
               part_busy[sel] = 1'b1;
               g.granted = 1'b1;
               g.chosen = pfa_pkg::SLOT_W'(sel);
            end
         end
         pfa_pkg::KIND_RELEASE: begin
            for (int j = 0; j < TABLE_DEPTH; j++) part_busy[j] = 1'b0;
         end
         default: ;
      endcase
      return g;
   endfunction

   // Driver: holds a stalled transfer, otherwise offers the next pending item at random.
   always @(posedge clock) begin : drive
      alloc_item_type nxt;
      bit fire;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         fire = req_valid && !req_stall;
         if (req_valid && req_stall) input_stall_cycles++;
         if (fire) begin
            grant_q.push_back(alloc_predict(req_kind, req_slot, req_size));
            items_taken++;
         end
         if (req_valid && !fire) begin
            req_valid <= 1'b1;
         end else if (item_q.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
            nxt = item_q.pop_front();
            req_valid <= 1'b1;
            req_kind <= nxt.kind;
            req_slot <= nxt.slot;
            req_size <= nxt.size;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: checks each result transfer and drives the receiver's stall.
   always @(posedge clock) begin : observe
      alloc_grant_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (rsp_granted) grants_seen++;
            if (grant_q.size() == 0) begin
               report_mismatch("result arrived with nothing expected");
            end else begin
               want = grant_q.pop_front();
               if (rsp_granted !== want.granted)
                  report_mismatch($sformatf("granted %b, expected %b",
                                            rsp_granted, want.granted));
               if (rsp_chosen_slot !== want.chosen)
                  report_mismatch($sformatf("chosen_slot %0d, expected %0d",
                                            rsp_chosen_slot, want.chosen));
            end
         end
         if (hold_pending) begin
            hold_left = HOLD_CYCLES;
            hold_pending = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rx_stall_pct);
         end
      end
   end

   // A cycle counts as quiet only when work is outstanding and nothing moves.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
             || (!req_valid && grant_q.size() == 0))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no transfer for %0d cycles with work outstanding", QUIET_LIMIT);
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   task automatic queue_item(input logic [pfa_pkg::KIND_W-1:0] kind,
                             input logic [pfa_pkg::SLOT_W-1:0] slot,
                             input logic [pfa_pkg::SIZE_W-1:0] size);
      alloc_item_type it;
      it.kind = kind;
      it.slot = slot;
      it.size = size;
      item_q.push_back(it);
   endtask

   // Mix of tiny sizes (for ties), extremes, values up to 1000 and fully random values.
   function automatic logic [pfa_pkg::SIZE_W-1:0] pick_size();
      case ($urandom_range(0, 3))
         0: return pfa_pkg::SIZE_W'($urandom_range(0, 8));
         1: return pfa_pkg::SIZE_W'($urandom);
         2: return $urandom_range(0, 1) ? {pfa_pkg::SIZE_W{1'b1}} : '0;
         default: return pfa_pkg::SIZE_W'($urandom_range(0, 1000));
      endcase
   endfunction

   task automatic wait_idle();
      @(negedge clock);
      while (item_q.size() != 0 || req_valid || grant_q.size() != 0) @(negedge clock);
      repeat (16) @(negedge clock);
   endtask

   task automatic write_rule(input logic [pfa_pkg::MODE_W-1:0] rule);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= rule;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      fit_rule = rule;
   endtask

   // A phase is mostly load/request/release runs with some undefined kinds and stray loads.
   task automatic fill_phase(input int target);
      int count;
      int loads;
      int asks;
      count = 0;
      while (count < target) begin
         loads = $urandom_range(1, TABLE_DEPTH);
         asks = $urandom_range(1, TABLE_DEPTH + 1);
         repeat (loads) begin
            queue_item(pfa_pkg::KIND_LOAD,
                       pfa_pkg::SLOT_W'($urandom_range(0, TABLE_DEPTH - 1)), pick_size());
            count++;
         end
         repeat (asks) begin
            if ($urandom_range(0, 7) == 0) begin
               if ($urandom_range(0, 1))
                  queue_item(KIND_UNDEF, pfa_pkg::SLOT_W'($urandom),
                             pfa_pkg::SIZE_W'($urandom));
               else
                  queue_item(pfa_pkg::KIND_LOAD, pfa_pkg::SLOT_W'($urandom), pick_size());
               count++;
            end
            queue_item(pfa_pkg::KIND_REQUEST, pfa_pkg::SLOT_W'($urandom), pick_size());
            count++;
         end
         if ($urandom_range(0, 3) != 0) begin
            queue_item(pfa_pkg::KIND_RELEASE, pfa_pkg::SLOT_W'($urandom),
                       pfa_pkg::SIZE_W'($urandom));
            count++;
         end
      end
   endtask

   initial begin : stimulus
      logic [pfa_pkg::MODE_W-1:0] phase_rule[8];
      int tx_profile[4];
      int rx_profile[4];
      phase_rule = '{pfa_pkg::MODE_BEST, pfa_pkg::MODE_WORST, pfa_pkg::MODE_FIRST, MODE_UNDEF,
                     pfa_pkg::MODE_WORST, pfa_pkg::MODE_BEST, MODE_UNDEF, pfa_pkg::MODE_FIRST};
      tx_profile = '{0, 62, 0, 36};
      rx_profile = '{0, 0, 62, 36};

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset rule, first fit.
      @(negedge clock);
      queue_item(pfa_pkg::KIND_REQUEST, 3'd7, 16'd0);      // zero size fits an empty partition
      queue_item(pfa_pkg::KIND_REQUEST, 3'd0, 16'd0);
      queue_item(pfa_pkg::KIND_RELEASE, 3'd0, 16'd0);
      queue_item(pfa_pkg::KIND_LOAD, 3'd0, 16'd100);
      queue_item(pfa_pkg::KIND_LOAD, 3'd1, 16'd50);
      queue_item(pfa_pkg::KIND_LOAD, 3'd2, 16'd200);
      queue_item(pfa_pkg::KIND_LOAD, 3'd3, 16'd50);
      queue_item(pfa_pkg::KIND_LOAD, 3'd4, 16'hFFFF);
      queue_item(pfa_pkg::KIND_LOAD, 3'd5, 16'd0);
      queue_item(pfa_pkg::KIND_LOAD, 3'd6, 16'd300);
      queue_item(pfa_pkg::KIND_LOAD, 3'd7, 16'd150);
      queue_item(pfa_pkg::KIND_REQUEST, 3'd0, 16'd60);
      queue_item(pfa_pkg::KIND_LOAD, 3'd0, 16'd10);        // allocated partition keeps its mark
      queue_item(pfa_pkg::KIND_REQUEST, 3'd0, 16'd5);
      queue_item(pfa_pkg::KIND_REQUEST, 3'd0, 16'hFFFF);
      queue_item(pfa_pkg::KIND_REQUEST, 3'd0, 16'hFFFF);   // nothing left that fits
      queue_item(KIND_UNDEF, 3'd7, 16'hFFFF);
      queue_item(pfa_pkg::KIND_RELEASE, 3'd7, 16'hFFFF);
      queue_item(pfa_pkg::KIND_REQUEST, 3'd0, 16'hFFFF);
      queue_item(pfa_pkg::KIND_REQUEST, 3'd0, 16'd1);
      wait_idle();

      for (int p = 0; p < 8; p++) begin
         write_rule(phase_rule[p]);
         @(negedge clock);
         tx_idle_pct = tx_profile[p % 4];
         rx_stall_pct = rx_profile[p % 4];
         fill_phase(85);
         // Long receiver hold-off while the sender keeps offering, to back up the input.
         if (p == 0) hold_pending = 1;
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (grant_q.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived", grant_q.size()));
      $display("Ran %0d transfers in and %0d results out (%0d granted) under all fit rules.",
               items_taken, results_seen, grants_seen);
      $display("Idle and stall mixes were exercised; input was held back for %0d cycles.",
               input_stall_cycles);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

### filelist.f
hdl/pfa_pkg.sv
hdl/pfa_datapath.sv
hdl/pfa_ctrl.sv
hdl/partition_fit_allocator.sv
verif/partition_fit_allocator_tb.sv
